// ===== rtl/core/gtp_pkg.sv =====
package gtp_pkg;

    // String layout: fourteen digits followed by the terminator.
    localparam int unsigned DigitCount = 14;
    localparam logic [4:0]  PosLastDigit = 5'd13;
    localparam logic [4:0]  PosTerm = 5'd14;
    localparam logic [4:0]  PosMax = 5'd31;
    localparam logic [7:0]  CharZero = 8'h30;
    localparam logic [7:0]  CharNine = 8'h39;
    localparam logic [7:0]  CharZ = 8'h5A;

    // Range limits.
    localparam logic [6:0]  HourMax = 7'd23;
    localparam logic [6:0]  MinuteMax = 7'd59;
    localparam logic [6:0]  SecondMax = 7'd60;

    localparam int unsigned QueueDepthDefault = 2;

    // One finished string handed from the front to the back.
    typedef struct packed {
        logic                  fmt_ok;
        logic [13:0][3:0]      digits;
    } t_job;

    // One decoded result.
    typedef struct packed {
        logic        valid_res;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_result;

    // Two decimal digits to a binary value, 0..99.
    function automatic logic [6:0] pair_val(input logic [3:0] hi, input logic [3:0] lo);
        logic [6:0] hi_w;
        hi_w = {3'b000, hi};
        return (hi_w << 3) + (hi_w << 1) + {3'b000, lo};
    endfunction

    // Length of a month; zero for a month code outside 1..12.
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/core/generalized_time_parser_core.sv =====
// Time string parser. The input channel takes one ASCII character per item
// (i_character) with i_last_char marking the final character of a string.
// Each string gives exactly one result item on the output channel: the
// decoded year, month, day, hour, minute and second with o_valid_res set,
// or o_valid_res clear and every date field zero when the string is not
// fourteen digits followed by 'Z' or a field is out of range.
// Throughput is one character per cycle while o_stall is low. The edge that
// accepts the final character writes the string into the queue; once the
// output register is empty or being taken, an edge loads the decoded result
// into it and o_valid rises.
// The queue holds QueueDepth finished strings; o_stall rises only while it
// is full, which happens when the receiver holds i_stall long enough.
// A stalled result holds its value on the output ports until taken, while
// the front keeps accepting characters until the queue is full.
// Synchronous reset clears the character position, the format flag, the
// queue and the output valid; the digit store needs no clearing because a
// string only decodes once all fourteen digits of it have been written.
module generalized_time_parser_core #(
    parameter int unsigned QueueDepth = gtp_pkg::QueueDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_character,
    input  logic        i_last_char,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_valid_res,
    output logic [13:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);
    import gtp_pkg::*;

    logic    in_accept;
    logic    push;
    t_job    push_job;
    t_job    head_job;
    logic    head_valid;
    logic    pop;
    logic    q_full;
    t_result result;

    assign o_stall   = q_full;
    assign in_accept = i_valid && !o_stall;

    // Front: position tracking, format check and digit capture.
    gtp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_character (i_character),
        .i_last_char (i_last_char),
        .o_push      (push),
        .o_job       (push_job)
    );

    // Queue of finished strings between front and back.
    gtp_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_job       (push_job),
        .i_pop       (pop),
        .o_head      (head_job),
        .o_not_empty (head_valid),
        .o_full      (q_full)
    );

    // Back: decode, range check and output register.
    gtp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_valid (head_valid),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_result    (result)
    );

    assign o_valid_res = result.valid_res;
    assign o_year      = result.year;
    assign o_month     = result.month;
    assign o_day       = result.day;
    assign o_hour      = result.hour;
    assign o_minute    = result.minute;
    assign o_second    = result.second;

    // A valid result always carries in-range fields.
    a_valid_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_res |-> o_month >= 4'd1 && o_month <= 4'd12 && o_day != 5'd0
            && o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd60)
        else $error("valid result with a field out of range");

    // A rejected string clears every field.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_valid_res |-> o_year == 14'd0 && o_month == 4'd0 && o_day == 5'd0
            && o_hour == 5'd0 && o_minute == 6'd0 && o_second == 6'd0)
        else $error("invalid result with a nonzero field");

    // A queued string reaches the output register unless the output is held.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head_valid && !(o_valid && i_stall) |=> o_valid)
        else $error("queued string not moved to the output");

endmodule

// ===== rtl/core/gtp_front.sv =====
module gtp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_character,
    input  logic           i_last_char,
    output logic           o_push,
    output gtp_pkg::t_job  o_job
);
    import gtp_pkg::*;

    logic [4:0]       r_pos;
    logic [4:0]       n_pos;
    logic             r_fmt_err;
    logic             n_fmt_err;
    logic [13:0][3:0] r_digits;
    logic             is_digit;
    logic             in_digits;

    assign is_digit  = (i_character >= CharZero) && (i_character <= CharNine);
    assign in_digits = (r_pos <= PosLastDigit);

    // Position count and format flag; both restart after the final character.
    always_comb begin
        n_pos     = r_pos;
        n_fmt_err = r_fmt_err;
        if (i_accept) begin
            if (in_digits && !is_digit) begin
                n_fmt_err = 1'b1;
            end
            if (i_last_char) begin
                n_pos     = '0;
                n_fmt_err = 1'b0;
            end else if (r_pos != PosMax) begin
                n_pos = r_pos + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_fmt_err <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_fmt_err <= n_fmt_err;
        end
    end

    // Digit store, written at the current position.
    always_ff @(posedge i_clk) begin
        if (i_accept && in_digits && is_digit) begin
            r_digits[r_pos[3:0]] <= i_character[3:0];
        end
    end

    // A final character hands the whole string to the queue.
    assign o_push        = i_accept && i_last_char;
    assign o_job.fmt_ok  = (r_pos == PosTerm) && (i_character == CharZ) && !r_fmt_err;
    assign o_job.digits  = r_digits;

endmodule

// ===== rtl/core/gtp_queue.sv =====
module gtp_queue #(
    parameter int unsigned Depth = gtp_pkg::QueueDepthDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gtp_pkg::t_job  i_job,
    input  logic           i_pop,
    output gtp_pkg::t_job  o_head,
    output logic           o_not_empty,
    output logic           o_full
);
    import gtp_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    t_job            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full      = (r_count == CntFull);
    assign o_not_empty = (r_count != '0);
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_head      = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/core/gtp_back.sv =====
module gtp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gtp_pkg::t_job     i_job,
    input  logic              i_job_valid,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output gtp_pkg::t_result  o_result
);
    import gtp_pkg::*;

    logic [6:0]  p_cent;
    logic [6:0]  p_yy;
    logic [6:0]  p_mon;
    logic [6:0]  p_day;
    logic [6:0]  p_hour;
    logic [6:0]  p_min;
    logic [6:0]  p_sec;
    logic [13:0] year;
    logic        leap;
    logic [4:0]  dim;
    logic        ok;
    t_result     n_result;
    logic        r_valid;
    t_result     r_result;

    // Digit pairs to binary values.
    assign p_cent = pair_val(i_job.digits[0], i_job.digits[1]);
    assign p_yy   = pair_val(i_job.digits[2], i_job.digits[3]);
    assign p_mon  = pair_val(i_job.digits[4], i_job.digits[5]);
    assign p_day  = pair_val(i_job.digits[6], i_job.digits[7]);
    assign p_hour = pair_val(i_job.digits[8], i_job.digits[9]);
    assign p_min  = pair_val(i_job.digits[10], i_job.digits[11]);
    assign p_sec  = pair_val(i_job.digits[12], i_job.digits[13]);

    // The product is formed at full year width so no bits are lost.
    assign year = 14'(p_cent) * 14'd100 + 14'(p_yy);

    // Since 100 is a multiple of four, the year's residues come from the pairs.
    assign leap = (p_yy[1:0] == 2'b00) && ((p_yy != '0) || (p_cent[1:0] == 2'b00));
    assign dim  = month_len(p_mon[3:0], leap);

    // Range checks; an invalid string clears every field.
    always_comb begin
        ok = i_job.fmt_ok && (p_mon inside {[7'd1:7'd12]});
        if (p_day == '0 || p_day > {2'b00, dim}) begin
            ok = 1'b0;
        end
        if (p_hour > HourMax || p_min > MinuteMax || p_sec > SecondMax) begin
            ok = 1'b0;
        end
        n_result = '0;
        if (ok) begin
            n_result.valid_res = 1'b1;
            n_result.year      = year;
            n_result.month     = p_mon[3:0];
            n_result.day       = p_day[4:0];
            n_result.hour      = p_hour[4:0];
            n_result.minute    = p_min[5:0];
            n_result.second    = p_sec[5:0];
        end
    end

    // Output register; it reloads whenever it is empty or being taken.
    assign o_pop = i_job_valid && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== sim/generalized_time_parser_core_test.sv =====
module generalized_time_parser_core_test;

    import gtp_pkg::*;

    localparam int IdleLimit = 3000;
    localparam int HoldCycles = 150;
    localparam int PhaseItems = 250;

    typedef enum int {
        STR_GOOD,
        STR_CORRUPT,
        STR_LENGTH,
        STR_NOISE
    } str_kind_e;

    // Decodes the character stream alongside the block and checks its dates.
    class time_string_checker;
        logic [4:0]  char_pos;
        bit          bad_format;
        logic [3:0]  digits [DigitCount];
        t_result     expected_dates [$];
        int          mismatches;
        int          n_valid;
        int          n_invalid;

        function new();
            char_pos = '0;
            bad_format = 1'b0;
            foreach (digits[i]) digits[i] = '0;
            mismatches = 0;
            n_valid = 0;
            n_invalid = 0;
        endfunction

        function int pair(int idx);
            return digits[idx] * 10 + digits[idx + 1];
        endfunction

        function int month_length(int yr, int mon);
            bit leap;
            leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
            case (mon)
                2: return leap ? 29 : 28;
                4, 6, 9, 11: return 30;
                default: return 31;
            endcase
        endfunction

        // Called for every accepted character; queues a date on the final one.
        function void take_char(logic [7:0] ch, logic last);
            t_result    r;
            logic [7:0] val;
            int         yr, mon, dd, hh, mm, ss;
            bit         ok;
            if (char_pos <= PosLastDigit) begin
                if (ch >= CharZero && ch <= CharNine) begin
                    val = ch - CharZero;
                    digits[char_pos] = val[3:0];
                end else begin
                    bad_format = 1'b1;
                end
            end
            if (!last) begin
                if (char_pos != PosMax) char_pos = char_pos + 5'd1;
                return;
            end
            ok = (char_pos == PosTerm) && (ch == CharZ) && !bad_format;
            yr = pair(0) * 100 + pair(2);
            mon = pair(4);
            dd = pair(6);
            hh = pair(8);
            mm = pair(10);
            ss = pair(12);
            r = '0;
            if (ok && mon >= 1 && mon <= 12 && dd >= 1 && dd <= month_length(yr, mon)
                    && hh <= HourMax && mm <= MinuteMax && ss <= SecondMax) begin
                r.valid_res = 1'b1;
                r.year = yr[13:0];
                r.month = mon[3:0];
                r.day = dd[4:0];
                r.hour = hh[4:0];
                r.minute = mm[5:0];
                r.second = ss[5:0];
            end
            expected_dates.insert(expected_dates.size(), r);
            char_pos = '0;
            bad_format = 1'b0;
        endfunction

        // Compares one delivered result with the oldest queued date.
        function void check_decoded(t_result got);
            t_result exp;
            bit      bad;
            if (expected_dates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: result with nothing expected: ",
                              "valid=%0b %0d-%0d-%0d %0d:%0d:%0d"},
                             $time, got.valid_res, got.year, got.month, got.day,
                             got.hour, got.minute, got.second);
                return;
            end
            exp = expected_dates.pop_front();
            if (exp.valid_res) n_valid++;
            else n_invalid++;
            bad = (got.valid_res !== exp.valid_res) || (got.year !== exp.year)
                || (got.month !== exp.month) || (got.day !== exp.day)
                || (got.hour !== exp.hour) || (got.minute !== exp.minute)
                || (got.second !== exp.second);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch: expected valid=%0b %0d-%0d-%0d %0d:%0d:%0d, ",
                              "got valid=%0b %0d-%0d-%0d %0d:%0d:%0d"},
                             $time, exp.valid_res, exp.year, exp.month, exp.day,
                             exp.hour, exp.minute, exp.second,
                             got.valid_res, got.year, got.month, got.day,
                             got.hour, got.minute, got.second);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_character;
    logic        i_last_char;
    logic        o_valid;
    logic        i_stall;
    logic        o_valid_res;
    logic [13:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;

    time_string_checker checker_h = new();

    logic [7:0] str [$];
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    bit         start_hold = 1'b0;
    int         chars_sent = 0;
    int         strings_sent = 0;
    int         idle_cycles = 0;

    generalized_time_parser_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_character (i_character),
        .i_last_char (i_last_char),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_valid_res (o_valid_res),
        .o_year      (o_year),
        .o_month     (o_month),
        .o_day       (o_day),
        .o_hour      (o_hour),
        .o_minute    (o_minute),
        .o_second    (o_second)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (start_hold) begin
                start_hold = 1'b0;
                hold_left = HoldCycles - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Both handshakes are observed here, along with the idle watchdog.
    always @(posedge i_clk) begin
        t_result got;
        bit      moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_valid && !o_stall) begin
                checker_h.take_char(i_character, i_last_char);
                moved = 1'b1;
            end
            if (o_valid && !i_stall) begin
                got.valid_res = o_valid_res;
                got.year = o_year;
                got.month = o_month;
                got.day = o_day;
                got.hour = o_hour;
                got.minute = o_minute;
                got.second = o_second;
                checker_h.check_decoded(got);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("%0t: no handshake for %0d cycles", $time, IdleLimit);
                $display("FAIL generalized_time_parser_core");
                $finish;
            end
        end
    end

    // Offers one character and returns at the falling edge after it is taken.
    task automatic send_char(input logic [7:0] ch, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_character <= ch;
        i_last_char <= last;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_string();
        foreach (str[i]) send_char(str[i], i == str.size() - 1);
        strings_sent++;
    endtask

    // Holds the input quiet until every queued date has been delivered.
    task automatic wait_drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (checker_h.expected_dates.size() != 0) @(negedge i_clk);
    endtask

    // Adds one character at the end of the string being built.
    function automatic void append_char(logic [7:0] c);
        str.insert(str.size(), c);
    endfunction

    function automatic void push_pair(int v);
        append_char(8'(CharZero + v / 10));
        append_char(8'(CharZero + v % 10));
    endfunction

    function automatic void build_fields(int yr, int mon, int dd, int hh, int mm, int ss);
        str.delete();
        push_pair(yr / 100);
        push_pair(yr % 100);
        push_pair(mon);
        push_pair(dd);
        push_pair(hh);
        push_pair(mm);
        push_pair(ss);
        append_char(CharZ);
    endfunction

    // Well-formed string whose fields sit mostly in range, often at the edges.
    function automatic void build_random_fields();
        int yr, mon, dd, hh, mm, ss, r;
        case ($urandom_range(3))
            0: yr = $urandom_range(9999);
            1: yr = $urandom_range(24) * 400;
            2: yr = $urandom_range(99) * 100;
            default: yr = $urandom_range(2499) * 4;
        endcase
        mon = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(12, 1);
        r = $urandom_range(9);
        dd = (r == 0) ? $urandom_range(99) : (r < 4) ? $urandom_range(32, 27)
            : $urandom_range(28, 1);
        hh = ($urandom_range(19) == 0) ? $urandom_range(99) : $urandom_range(24);
        mm = ($urandom_range(19) == 0) ? $urandom_range(99) : $urandom_range(60);
        ss = ($urandom_range(19) == 0) ? $urandom_range(99) : $urandom_range(61);
        build_fields(yr, mon, dd, hh, mm, ss);
    endfunction

    task automatic send_random_string();
        int        pick, len;
        str_kind_e kind;
        pick = $urandom_range(99);
        kind = (pick < 60) ? STR_GOOD : (pick < 75) ? STR_CORRUPT
            : (pick < 90) ? STR_LENGTH : STR_NOISE;
        build_random_fields();
        case (kind)
            STR_CORRUPT: begin
                str[$urandom_range(14)] = 8'($urandom_range(255));
            end
            STR_LENGTH: begin
                // Too short or too long, including past the saturation point.
                len = $urandom_range(40, 1);
                if (len == 15) len = 16;
                void'(str.pop_back());
                while (str.size() > len - 1) void'(str.pop_back());
                while (str.size() < len - 1)
                    append_char($urandom_range(1) ? 8'(CharZero + $urandom_range(9))
                                                  : 8'($urandom_range(255)));
                append_char(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : CharZ);
            end
            STR_NOISE: begin
                str.delete();
                len = $urandom_range(20, 1);
                repeat (len) append_char(8'($urandom_range(255)));
            end
            default: ;
        endcase
        send_string();
    endtask

    // Main stimulus sequence.
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_character = '0;
        i_last_char = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: lone terminator, extreme bytes as a one-character string,
        // and the largest valid date with a leap second.
        send_char(CharZ, 1'b1);
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        build_fields(9999, 12, 31, 23, 59, 60);
        send_string();
        strings_sent += 3;
        wait_drain();

        // Random phases with different amounts of idling on each side.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 46; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 46; end
                default: begin send_idle_pct = 19; stall_pct = 19; end
            endcase
            if (phase == 0) begin
                // Fill the block behind a long receiver hold-off.
                start_hold = 1'b1;
                repeat (40) begin
                    send_char(8'($urandom_range(255)), 1'b1);
                    strings_sent++;
                end
            end
            while (chars_sent < PhaseItems * (phase + 1)) send_random_string();
            wait_drain();
        end

        repeat (10) @(negedge i_clk);
        $display("Sent %0d characters in %0d strings across four idling mixes.",
                 chars_sent, strings_sent);
        $display("Dates checked: %0d valid, %0d rejected; mismatches: %0d.",
                 checker_h.n_valid, checker_h.n_invalid, checker_h.mismatches);
        if (checker_h.mismatches == 0 && checker_h.expected_dates.size() == 0) begin
            $display("PASS generalized_time_parser_core");
        end else begin
            $display("FAIL generalized_time_parser_core");
        end
        $finish;
    end

endmodule
